@@ hw/rtl/sfla_pkg.sv @@
`default_nettype none
package sfla_pkg;
    localparam int MaxSlabsDef   = 16;
    localparam int MaxObjectsDef = 256;
    localparam int CfgIdxW       = 1;
    localparam int CfgDataW      = 13;
    localparam logic [CfgIdxW-1:0] CfgObjects = 1'b0;
    localparam logic [CfgIdxW-1:0] CfgLimit   = 1'b1;

    localparam logic [1:0] TagUnused  = 2'd0;
    localparam logic [1:0] TagFree    = 2'd1;
    localparam logic [1:0] TagPartial = 2'd2;
    localparam logic [1:0] TagFull    = 2'd3;

    localparam logic [1:0] StOk     = 2'd0;
    localparam logic [1:0] StNoSlab = 2'd1;
    localparam logic [1:0] StBadFree = 2'd2;

    localparam logic [12:0] CountMax = 13'h1FFF;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  granted_slab;
        logic [7:0]  granted_index;
        logic [12:0] free_total;
    } t_result;

    // Commands from the controller to the datapath.
    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_DECIDE,
        CMD_BUILD,
        CMD_FINISH,
        CMD_REAP
    } t_cmd;

    typedef struct packed {
        t_cmd cmd;
    } t_ctl;

    typedef struct packed {
        logic build_needed; // decision calls for building a fresh slab chain
        logic build_last;   // final link of the chain is being written
        logic reap_needed;  // a free emptied a slab and reaping must run
        logic reap_more;    // another free slab should be released
    } t_stat;
endpackage
`default_nettype wire

@@ hw/rtl/sfla_if.sv @@
`default_nettype none
interface sfla_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/slab_free_list_allocator_core.sv @@
`default_nettype none
// Channel | Direction | Word
// in      | sink      | action, slab_id, object_index
// out     | source    | status, granted_slab, granted_index, free_total
// cfg     | write     | objects_per_slab (0), reap limit (1)
//
// An ordinary allocate or free runs through accept, decide (chain read), finish
// (link write) and emit. Allocating from a fresh slab adds a build step in which
// its chain is written slot by slot; a reaping free adds a reap step that releases
// free slabs one by one and then sees that reaping is over. Reset is synchronous
// and active low; the link memory needs no clearing. A stalled output holds its word
// in the output register; the next word is processed and then waits in emit.
module slab_free_list_allocator_core
    import sfla_pkg::*;
#(
    parameter int MAX_SLABS   = MaxSlabsDef,
    parameter int MAX_OBJECTS = MaxObjectsDef
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    sfla_if.sink                     in_ch,
    sfla_if.source                   out_ch,
    input  wire logic                i_cfg_we,
    input  wire logic [CfgIdxW-1:0]  i_cfg_idx,
    input  wire logic [CfgDataW-1:0] i_cfg_data
);
    logic [8:0]  r_ops;
    logic [12:0] r_limit;
    logic        r_ovalid;
    t_result     r_odata;
    t_ctl        ctl;
    t_stat       stat;
    t_result     res;
    logic        busy, done, start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ops   <= 9'd256;
            r_limit <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CfgObjects: r_ops   <= i_cfg_data[8:0];
                CfgLimit:   r_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The engine takes a new word while the previous result waits to be taken.
    assign in_ch.ready = !busy;
    assign start       = in_ch.valid && in_ch.ready;

    sfla_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_out_free(!r_ovalid || out_ch.ready), .i_stat(stat),
        .o_ctl(ctl), .o_busy(busy), .o_done(done)
    );

    sfla_dpath #(.MAX_SLABS(MAX_SLABS), .MAX_OBJECTS(MAX_OBJECTS)) u_dpath (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(start),
        .i_action(in_ch.data[12]), .i_slab_id(in_ch.data[11:8]),
        .i_object_index(in_ch.data[7:0]),
        .i_objects_per_slab(r_ops), .i_reap_limit(r_limit),
        .i_ctl(ctl), .o_stat(stat), .o_result(res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else if (done) r_ovalid <= 1'b1;
        else if (out_ch.ready) r_ovalid <= 1'b0;
        if (done) r_odata <= res;
    end

    assign out_ch.valid = r_ovalid;
    assign out_ch.data  = r_odata;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !in_ch.ready) else $error("accept while busy");
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> r_ovalid) else $error("result lost");
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_odata.status != 2'd3)) else $error("bad status");
endmodule
`default_nettype wire

@@ hw/rtl/sfla_ctrl.sv @@
`default_nettype none
module sfla_ctrl
    import sfla_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_start,
    input  wire logic  i_out_free,
    input  wire t_stat i_stat,
    output t_ctl       o_ctl,
    output logic       o_busy,
    output logic       o_done
);
    typedef enum logic [2:0] {
        S_IDLE, S_DECIDE, S_BUILD, S_FINISH, S_REAP, S_EMIT
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state   = r_state;
        o_ctl.cmd = CMD_NOP;
        o_done    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                o_ctl.cmd = CMD_DECIDE;
                if (i_stat.build_needed) n_state = S_BUILD;
                else n_state = S_FINISH;
            end
            S_BUILD: begin
                o_ctl.cmd = CMD_BUILD;
                if (i_stat.build_last) n_state = S_FINISH;
            end
            S_FINISH: begin
                o_ctl.cmd = CMD_FINISH;
                if (i_stat.reap_needed) n_state = S_REAP;
                else n_state = S_EMIT;
            end
            S_REAP: begin
                o_ctl.cmd = CMD_REAP;
                if (!i_stat.reap_more) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    assign o_busy = (r_state != S_IDLE);
endmodule
`default_nettype wire

@@ hw/rtl/sfla_dpath.sv @@
`default_nettype none
module sfla_dpath
    import sfla_pkg::*;
#(
    parameter int MAX_SLABS   = MaxSlabsDef,
    parameter int MAX_OBJECTS = MaxObjectsDef
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_load,
    input  wire logic        i_action,
    input  wire logic [3:0]  i_slab_id,
    input  wire logic [7:0]  i_object_index,
    input  wire logic [8:0]  i_objects_per_slab,
    input  wire logic [12:0] i_reap_limit,
    input  wire t_ctl        i_ctl,
    output t_stat            o_stat,
    output t_result          o_result
);
    localparam int SW = (MAX_SLABS > 1) ? $clog2(MAX_SLABS) : 1;
    localparam int PW = $clog2(MAX_SLABS + 1);
    localparam int OW = $clog2(MAX_OBJECTS);
    localparam int CW = $clog2(MAX_OBJECTS + 1);
    localparam int AW = SW + OW;
    localparam logic [PW-1:0] NoneSlab = PW'(MAX_SLABS);

    // Slot chain memory: one write, one registered read per cycle.
    logic [OW-1:0] r_links [MAX_SLABS*MAX_OBJECTS];
    logic [OW-1:0] r_link_rd;
    logic          mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [OW-1:0] mem_wd;

    logic [OW-1:0] r_fhead [MAX_SLABS];
    logic [CW-1:0] r_inuse [MAX_SLABS];
    logic [1:0]    r_tag   [MAX_SLABS];
    logic [PW-1:0] r_next  [MAX_SLABS];
    logic [PW-1:0] r_prev  [MAX_SLABS];
    logic [PW-1:0] r_free_head, r_part_head, r_part_tail, r_cur;
    logic [12:0]   r_count;

    logic          r_act;
    logic [3:0]    r_sid;
    logic [7:0]    r_oidx;
    logic [PW-1:0] r_sel;     // slab chosen for this word
    logic          r_build;
    logic [CW-1:0] r_bcnt;
    t_result       r_res;

    // Clamped slot count.
    logic [CW-1:0] n_slots;
    always_comb begin
        if (i_objects_per_slab < 9'd2) n_slots = CW'(2);
        else if ({23'd0, i_objects_per_slab} > MAX_OBJECTS) n_slots = CW'(MAX_OBJECTS);
        else n_slots = CW'(i_objects_per_slab);
    end

    // Lowest unused slab.
    logic [PW-1:0] unused_sel;
    always_comb begin
        unused_sel = NoneSlab;
        for (int i = MAX_SLABS - 1; i >= 0; i--) begin
            if (r_tag[i] == TagUnused) unused_sel = PW'(i);
        end
    end

    // Slab that an allocate would serve from, in priority order.
    logic [PW-1:0] pick;
    always_comb begin
        if (r_cur != NoneSlab) pick = r_cur;
        else if (r_part_head != NoneSlab) pick = r_part_head;
        else if (r_free_head != NoneSlab) pick = r_free_head;
        else pick = unused_sel;
    end

    logic [SW-1:0] sel_i, sid_i, fh_i, pick_i;
    assign sel_i  = r_sel[SW-1:0];
    assign sid_i  = SW'(r_sid);
    assign fh_i   = r_free_head[SW-1:0];
    assign pick_i = pick[SW-1:0];

    logic free_ok;
    assign free_ok = ({28'd0, r_sid} < MAX_SLABS) && (r_tag[sid_i] != TagUnused)
                   && (r_inuse[sid_i] != '0) && ({1'b0, r_oidx} < 9'(n_slots));

    logic [13:0] cnt_add1, cnt_addn;
    logic [12:0] cnt_inc;
    assign cnt_add1 = {1'b0, r_count} + 14'd1;
    assign cnt_addn = {1'b0, r_count} + 14'(n_slots);
    assign cnt_inc  = (cnt_add1 > 14'(CountMax)) ? CountMax : cnt_add1[12:0];

    // The chain read is addressed during decide so that finish sees the link
    // behind the head slot of the slab that is about to be served.
    always_comb begin
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = '0;
        mem_ra = {pick_i, r_fhead[pick_i]};
        if (i_ctl.cmd == CMD_BUILD) begin
            mem_we = 1'b1;
            mem_wa = {sel_i, r_bcnt[OW-1:0]};
            mem_wd = OW'(r_bcnt + CW'(1));
        end else if (i_ctl.cmd == CMD_FINISH && r_act && free_ok) begin
            mem_we = 1'b1;
            mem_wa = {sid_i, OW'(r_oidx)};
            mem_wd = r_fhead[sid_i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_links[mem_wa] <= mem_wd;
        r_link_rd <= r_links[mem_ra];
    end

    assign o_stat.build_needed = (r_act == 1'b0) && (r_cur == NoneSlab)
        && (r_part_head == NoneSlab) && (r_free_head == NoneSlab) && (unused_sel != NoneSlab);
    assign o_stat.build_last  = (r_bcnt + CW'(1) >= n_slots);
    // Seen during finish: this free empties its slab and lifts the total over the limit.
    assign o_stat.reap_needed = r_act && free_ok && (r_inuse[sid_i] == CW'(1))
                              && (cnt_inc > i_reap_limit);
    assign o_stat.reap_more   = (r_free_head != NoneSlab) && (r_count >= i_reap_limit);
    assign o_result = r_res;

    // Command-driven payload and list update. Build reads no chain; the first
    // take from a fresh slab uses link 1 directly.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_SLABS; i++) begin
                r_inuse[i] <= '0;
                r_tag[i]   <= TagUnused;
            end
            r_free_head <= NoneSlab;
            r_part_head <= NoneSlab;
            r_part_tail <= NoneSlab;
            r_cur       <= NoneSlab;
            r_count     <= '0;
        end else begin
            if (i_load) begin
                r_act  <= i_action;
                r_sid  <= i_slab_id;
                r_oidx <= i_object_index;
            end
            unique case (i_ctl.cmd)
                CMD_DECIDE: begin
                    r_bcnt  <= '0;
                    r_build <= o_stat.build_needed;
                    r_sel   <= pick;
                    if (o_stat.build_needed) begin
                        r_fhead[unused_sel[SW-1:0]] <= '0;
                        r_inuse[unused_sel[SW-1:0]] <= '0;
                        r_prev[unused_sel[SW-1:0]]  <= NoneSlab;
                        r_next[unused_sel[SW-1:0]]  <= NoneSlab;
                        r_tag[unused_sel[SW-1:0]]   <= TagFree;
                        r_free_head <= unused_sel;
                        r_count <= cnt_addn > 14'(CountMax) ? CountMax : cnt_addn[12:0];
                    end
                end
                CMD_BUILD: r_bcnt <= r_bcnt + CW'(1);
                CMD_FINISH: begin
                    if (!r_act) begin
                        if (r_sel == NoneSlab) begin
                            r_res.status        <= StNoSlab;
                            r_res.granted_slab  <= '0;
                            r_res.granted_index <= '0;
                            r_res.free_total    <= r_count;
                        end else begin
                            r_res.status        <= StOk;
                            r_res.granted_slab  <= 4'(r_sel);
                            r_res.granted_index <= 8'(r_fhead[sel_i]);
                            r_fhead[sel_i] <= r_build ? OW'(1) : r_link_rd;
                            r_inuse[sel_i] <= r_inuse[sel_i] + CW'(1);
                            r_count <= (r_count != '0) ? r_count - 13'd1 : '0;
                            r_res.free_total <= (r_count != '0) ? r_count - 13'd1 : '0;
                            if (r_tag[sel_i] == TagFree) begin
                                // pop free list, push partial head
                                r_free_head <= r_next[sel_i];
                                if (r_next[sel_i] != NoneSlab)
                                    r_prev[r_next[sel_i][SW-1:0]] <= NoneSlab;
                                r_prev[sel_i] <= NoneSlab;
                                r_next[sel_i] <= r_part_head;
                                if (r_part_head != NoneSlab)
                                    r_prev[r_part_head[SW-1:0]] <= r_sel;
                                else r_part_tail <= r_sel;
                                r_part_head <= r_sel;
                                r_tag[sel_i] <= TagPartial;
                                r_cur <= r_sel;
                            end else if (r_inuse[sel_i] + CW'(1) >= n_slots) begin
                                if (r_prev[sel_i] != NoneSlab)
                                    r_next[r_prev[sel_i][SW-1:0]] <= r_next[sel_i];
                                else r_part_head <= r_next[sel_i];
                                if (r_next[sel_i] != NoneSlab)
                                    r_prev[r_next[sel_i][SW-1:0]] <= r_prev[sel_i];
                                else r_part_tail <= r_prev[sel_i];
                                r_tag[sel_i] <= TagFull;
                                r_cur <= NoneSlab;
                            end else begin
                                r_cur <= r_sel;
                            end
                        end
                    end else if (!free_ok) begin
                        r_res.status        <= StBadFree;
                        r_res.granted_slab  <= '0;
                        r_res.granted_index <= '0;
                        r_res.free_total    <= r_count;
                    end else begin
                        r_res.status        <= StOk;
                        r_res.granted_slab  <= '0;
                        r_res.granted_index <= '0;
                        r_res.free_total    <= cnt_inc;
                        r_count <= cnt_inc;
                        r_fhead[sid_i] <= OW'(r_oidx);
                        r_inuse[sid_i] <= r_inuse[sid_i] - CW'(1);
                        if (r_inuse[sid_i] == CW'(1)) begin
                            if (r_tag[sid_i] == TagPartial) begin
                                if (r_prev[sid_i] != NoneSlab)
                                    r_next[r_prev[sid_i][SW-1:0]] <= r_next[sid_i];
                                else r_part_head <= r_next[sid_i];
                                if (r_next[sid_i] != NoneSlab)
                                    r_prev[r_next[sid_i][SW-1:0]] <= r_prev[sid_i];
                                else r_part_tail <= r_prev[sid_i];
                            end
                            r_prev[sid_i] <= NoneSlab;
                            r_next[sid_i] <= r_free_head;
                            if (r_free_head != NoneSlab)
                                r_prev[fh_i] <= PW'(r_sid);
                            r_free_head <= PW'(r_sid);
                            r_tag[sid_i] <= TagFree;
                            if (r_cur == PW'(r_sid)) r_cur <= NoneSlab;
                        end else if (r_tag[sid_i] == TagFull) begin
                            r_next[sid_i] <= NoneSlab;
                            r_prev[sid_i] <= r_part_tail;
                            if (r_part_tail != NoneSlab)
                                r_next[r_part_tail[SW-1:0]] <= PW'(r_sid);
                            else r_part_head <= PW'(r_sid);
                            r_part_tail <= PW'(r_sid);
                            r_tag[sid_i] <= TagPartial;
                        end
                    end
                end
                CMD_REAP: begin
                    if (o_stat.reap_more) begin
                        r_free_head <= r_next[fh_i];
                        if (r_next[fh_i] != NoneSlab)
                            r_prev[r_next[fh_i][SW-1:0]] <= NoneSlab;
                        r_tag[fh_i]   <= TagUnused;
                        r_inuse[fh_i] <= '0;
                        r_count <= (r_count > 13'(n_slots)) ? r_count - 13'(n_slots) : '0;
                        r_res.free_total <= (r_count > 13'(n_slots))
                                          ? r_count - 13'(n_slots) : '0;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire
